/* rtl/tpps_pkg.sv */
// Package with the command and mode codes, timing constants and the program ROM of the sequencer.
`timescale 1ns / 1ps
`default_nettype none

package tpps_pkg;

    localparam int NUM_PROGRAMS       = 5;
    localparam int PHASES_PER_PROGRAM = 2;

    localparam logic [31:0] MS_HOUR = 32'd3600000;
    localparam logic [31:0] MS_DAY  = 32'd86400000;

    // Whole days: (elapsed >> 10) / 84375 as a multiply by a rounded-up reciprocal.
    localparam int          DAY_PRE_SHIFT = 10;
    localparam int          DAY_SHIFT     = 39;
    localparam logic [22:0] DAY_RECIP     = 23'd6515625;

    // Whole hours: (elapsed >> 7) / 28125 in the same way.
    localparam int          HOUR_PRE_SHIFT = 7;
    localparam int          HOUR_SHIFT     = 40;
    localparam logic [25:0] HOUR_RECIP     = 26'd39093747;

    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_START  = 3'd1,
        CMD_PAUSE  = 3'd2,
        CMD_RESUME = 3'd3,
        CMD_STOP   = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_RUN   = 2'd1,
        MODE_PAUSE = 2'd2,
        MODE_DONE  = 2'd3
    } run_mode_t;

    typedef struct packed {
        logic [5:0] days;
        logic [8:0] temp;
        logic [6:0] hum;
        logic       turning;
        logic [2:0] turn_hours;
    } phase_t;

    function automatic phase_t phase_entry(input logic [2:0] prog, input logic ph);
        phase_t p;
        p = '0;
        unique case ({prog, ph})
            4'b000_0: p = '{6'd18, 9'd375, 7'd57, 1'b1, 3'd4};
            4'b000_1: p = '{6'd3,  9'd372, 7'd68, 1'b0, 3'd0};
            4'b001_0: p = '{6'd25, 9'd375, 7'd55, 1'b1, 3'd4};
            4'b001_1: p = '{6'd3,  9'd372, 7'd70, 1'b0, 3'd0};
            4'b010_0: p = '{6'd14, 9'd375, 7'd55, 1'b1, 3'd4};
            4'b010_1: p = '{6'd2,  9'd372, 7'd68, 1'b0, 3'd0};
            4'b011_0: p = '{6'd25, 9'd375, 7'd55, 1'b1, 3'd4};
            4'b011_1: p = '{6'd3,  9'd372, 7'd68, 1'b0, 3'd0};
            4'b100_0: p = '{6'd21, 9'd375, 7'd55, 1'b1, 3'd4};
            4'b100_1: p = '{6'd3,  9'd372, 7'd68, 1'b0, 3'd0};
            default:  p = '0;
        endcase
        return p;
    endfunction

    // Length of the first phase of a program in milliseconds, modulo 2^32.
    function automatic logic [31:0] first_phase_ms(input logic [2:0] prog);
        phase_t p;
        p = phase_entry(prog, 1'b0);
        return 32'(32'(p.days) * MS_DAY);
    endfunction

    function automatic logic [31:0] turn_interval_ms(input logic [2:0] turn_hours);
        return 32'(32'(turn_hours) * MS_HOUR);
    endfunction

endpackage

`default_nettype wire

/* rtl/timed_phase_program_sequencer_top.sv */
// Top level of the timed phase program sequencer: command register, state update and result register.
`timescale 1ns / 1ps
`default_nettype none

// The sequencer takes one command request per clock cycle while the result side is not stalled,
// and returns exactly one result request for each. A request is held in an input register;
// from there the elapsed time of the current phase is split into whole days and hours by two
// parallel constant-reciprocal multipliers, the run state is updated, and the result is
// captured in the output register. These multipliers set the clock period. A stalled output
// register holds its result while the input register can still take one more request. Phase
// setpoints come from a built-in table of five two-phase programs; temperatures are in tenths
// of a degree Celsius.
module timed_phase_program_sequencer_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // cycle_select [2:0], now_ms [34:3], zero [39:35]
    input  wire logic [39:0] s_tdata,
    // func [2:0]
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // accepted [0], run_state [2:1], phase_index [4:3], elapsed_days [10:5],
    // elapsed_hours [15:11], setpoint_valid [16], temp_setpoint [25:17],
    // humidity_setpoint [32:26], turn_event [33], turner_position [34], zero [39:35]
    output logic [39:0]      m_tdata
);
    import tpps_pkg::*;

    localparam logic [3:0] NUM_PROGRAMS_W  = 4'(NUM_PROGRAMS);
    localparam logic [1:0] PHASE_LIMIT     = 2'(PHASES_PER_PROGRAM);

    logic        in_valid_reg;
    logic [2:0]  in_func_reg;
    logic [2:0]  in_sel_reg;
    logic [31:0] in_now_reg;
    logic        out_valid_reg;
    logic [39:0] out_data_reg;
    logic        advance;

    run_mode_t   mode_reg, mode_next;
    logic [2:0]  prog_reg, prog_next;
    logic [1:0]  phase_reg, phase_next;
    logic [31:0] phase_start_reg, phase_start_next;
    logic [31:0] last_turn_reg, last_turn_next;
    logic        turner_reg, turner_next;
    logic [5:0]  days_reg, days_next;
    logic [4:0]  hours_reg, hours_next;

    logic        accepted;
    logic        sp_valid;
    logic        turn_ev;

    phase_t      cur_ph;
    phase_t      sp_ph;
    logic [31:0] elapsed;
    logic [44:0] day_prod;
    logic [50:0] hour_prod;
    logic [5:0]  calc_days;
    logic [10:0] calc_hours_total;
    logic [10:0] day_hours;
    logic [10:0] hours_left;
    logic [31:0] since_turn;
    logic [1:0]  phase_inc;
    logic [8:0]  temp_out;
    logic [6:0]  hum_out;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Elapsed time in the current phase, split into days and hours.
    assign cur_ph           = phase_entry(prog_reg, phase_reg[0]);
    assign elapsed          = in_now_reg - phase_start_reg;
    assign day_prod         = 45'(elapsed[31:DAY_PRE_SHIFT]) * 45'(DAY_RECIP);
    assign hour_prod        = 51'(elapsed[31:HOUR_PRE_SHIFT]) * 51'(HOUR_RECIP);
    assign calc_days        = day_prod[DAY_SHIFT +: 6];
    assign calc_hours_total = hour_prod[HOUR_SHIFT +: 11];
    assign day_hours        = {1'b0, calc_days, 4'b0000} + {2'b00, calc_days, 3'b000};
    assign hours_left       = calc_hours_total - day_hours;
    assign since_turn       = in_now_reg - last_turn_reg;
    assign phase_inc        = phase_reg + 2'd1;

    always_comb begin
        mode_next        = mode_reg;
        prog_next        = prog_reg;
        phase_next       = phase_reg;
        phase_start_next = phase_start_reg;
        last_turn_next   = last_turn_reg;
        turner_next      = turner_reg;
        days_next        = days_reg;
        hours_next       = hours_reg;
        accepted         = 1'b1;
        sp_valid         = 1'b0;
        turn_ev          = 1'b0;
        case (cmd_t'(in_func_reg))
            CMD_START: begin
                if ({1'b0, in_sel_reg} >= NUM_PROGRAMS_W) begin
                    accepted = 1'b0;
                end else begin
                    mode_next        = MODE_RUN;
                    prog_next        = in_sel_reg;
                    phase_next       = 2'd0;
                    phase_start_next = in_now_reg;
                    last_turn_next   = in_now_reg;
                    turner_next      = 1'b0;
                    days_next        = '0;
                    hours_next       = '0;
                    sp_valid         = 1'b1;
                end
            end
            CMD_PAUSE: begin
                if (mode_reg == MODE_RUN) begin
                    mode_next = MODE_PAUSE;
                end
            end
            CMD_RESUME: begin
                if (mode_reg == MODE_PAUSE) begin
                    mode_next = MODE_RUN;
                    sp_valid  = 1'b1;
                end
            end
            CMD_STOP: begin
                mode_next = MODE_IDLE;
            end
            CMD_TICK: begin
                if (mode_reg == MODE_RUN) begin
                    days_next  = calc_days;
                    hours_next = hours_left[4:0];
                    if (calc_days >= cur_ph.days) begin
                        phase_next = phase_inc;
                        if (phase_inc >= PHASE_LIMIT) begin
                            mode_next = MODE_DONE;
                        end else begin
                            sp_valid         = 1'b1;
                            phase_start_next = phase_start_reg + first_phase_ms(prog_reg);
                        end
                    end else if (cur_ph.turning && cur_ph.turn_hours != 3'd0) begin
                        if (since_turn >= turn_interval_ms(cur_ph.turn_hours)) begin
                            turner_next    = !turner_reg;
                            last_turn_next = in_now_reg;
                            turn_ev        = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Setpoints of the phase that is current after this request.
    always_comb begin
        sp_ph    = phase_entry(prog_next, phase_next[0]);
        temp_out = '0;
        hum_out  = '0;
        if (sp_valid) begin
            temp_out = sp_ph.temp;
            hum_out  = sp_ph.hum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            mode_reg        <= MODE_IDLE;
            prog_reg        <= '0;
            phase_reg       <= '0;
            phase_start_reg <= '0;
            last_turn_reg   <= '0;
            turner_reg      <= 1'b0;
            days_reg        <= '0;
            hours_reg       <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg   <= 1'b1;
                mode_reg        <= mode_next;
                prog_reg        <= prog_next;
                phase_reg       <= phase_next;
                phase_start_reg <= phase_start_next;
                last_turn_reg   <= last_turn_next;
                turner_reg      <= turner_next;
                days_reg        <= days_next;
                hours_reg       <= hours_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_func_reg <= s_tuser;
            in_sel_reg  <= s_tdata[2:0];
            in_now_reg  <= s_tdata[34:3];
        end
        if (advance) begin
            out_data_reg <= {5'b00000, turner_next, turn_ev, hum_out, temp_out, sp_valid,
                             hours_next, days_next, phase_next, mode_next, accepted};
        end
    end

endmodule

`default_nettype wire

/* tb/tb_timed_phase_program_sequencer_top.sv */
// Self-checking testbench for the timed phase program sequencer, with directed and random command requests.
`timescale 1ns / 1ps

module tb_timed_phase_program_sequencer_top;
    import tpps_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam logic [31:0] WRAP_START  = 32'hFFFF_FF00;

    typedef struct packed {
        logic       turner_position;
        logic       turn_event;
        logic [6:0] humidity;
        logic [8:0] temp;
        logic       setpoint_valid;
        logic [4:0] hours;
        logic [5:0] days;
        logic [1:0] phase;
        logic [1:0] mode;
        logic       accepted;
    } status_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;

    run_mode_t   seq_mode;
    logic [2:0]  seq_prog;
    logic [1:0]  seq_phase;
    logic [31:0] seq_start_ms;
    logic [31:0] seq_last_turn_ms;
    logic        seq_turner;
    logic [5:0]  seq_days;
    logic [4:0]  seq_hours;

    status_t     pending_status[$];
    status_t     got_status;
    status_t     want_status;
    int unsigned requests_sent  = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    bit          send_quiet     = 0;
    bit          accept_quiet   = 0;

    timed_phase_program_sequencer_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic phase_t program_phase(input logic [2:0] prog, input logic ph);
        phase_t p;
        p = '0;
        if (prog < NUM_PROGRAMS) begin
            p.turning    = !ph;
            p.turn_hours = ph ? 3'd0 : 3'd4;
            p.temp       = ph ? 9'd372 : 9'd375;
            case (prog)
                3'd0: begin
                    p.days = ph ? 6'd3 : 6'd18;
                    p.hum  = ph ? 7'd68 : 7'd57;
                end
                3'd1: begin
                    p.days = ph ? 6'd3 : 6'd25;
                    p.hum  = ph ? 7'd70 : 7'd55;
                end
                3'd2: begin
                    p.days = ph ? 6'd2 : 6'd14;
                    p.hum  = ph ? 7'd68 : 7'd55;
                end
                3'd3: begin
                    p.days = ph ? 6'd3 : 6'd25;
                    p.hum  = ph ? 7'd68 : 7'd55;
                end
                default: begin
                    p.days = ph ? 6'd3 : 6'd21;
                    p.hum  = ph ? 7'd68 : 7'd55;
                end
            endcase
        end
        return p;
    endfunction

    // The current phase starts after all earlier phases have run their full length.
    function automatic logic [31:0] phase_start_ms();
        phase_t first;
        first = program_phase(seq_prog, 1'b0);
        return (seq_phase != 2'd0) ? seq_start_ms + first.days * MS_DAY : seq_start_ms;
    endfunction

    function automatic status_t sequencer_next_status(input logic [2:0] op, input logic [2:0] sel,
                                                      input logic [31:0] now_ms);
        status_t     s;
        phase_t      cur;
        logic [31:0] elapsed;
        logic [31:0] since_turn;
        logic [31:0] interval;
        s = '0;
        s.accepted = 1'b1;
        case (op)
            CMD_START: begin
                if (sel >= NUM_PROGRAMS) begin
                    s.accepted = 1'b0;
                end else begin
                    seq_mode         = MODE_RUN;
                    seq_prog         = sel;
                    seq_phase        = 2'd0;
                    seq_start_ms     = now_ms;
                    seq_last_turn_ms = now_ms;
                    seq_days         = '0;
                    seq_hours        = '0;
                    seq_turner       = 1'b0;
                    s.setpoint_valid = 1'b1;
                end
            end
            CMD_PAUSE: begin
                if (seq_mode == MODE_RUN) seq_mode = MODE_PAUSE;
            end
            CMD_RESUME: begin
                if (seq_mode == MODE_PAUSE) begin
                    seq_mode         = MODE_RUN;
                    s.setpoint_valid = 1'b1;
                end
            end
            CMD_STOP: seq_mode = MODE_IDLE;
            CMD_TICK: begin
                if (seq_mode == MODE_RUN) begin
                    cur       = program_phase(seq_prog, seq_phase[0]);
                    elapsed   = now_ms - phase_start_ms();
                    seq_days  = 6'(elapsed / MS_DAY);
                    seq_hours = 5'((elapsed % MS_DAY) / MS_HOUR);
                    if (seq_days >= cur.days) begin
                        seq_phase = seq_phase + 2'd1;
                        if (seq_phase >= PHASES_PER_PROGRAM) seq_mode = MODE_DONE;
                        else s.setpoint_valid = 1'b1;
                    end else if (cur.turning && cur.turn_hours != 3'd0) begin
                        interval   = cur.turn_hours * MS_HOUR;
                        since_turn = now_ms - seq_last_turn_ms;
                        if (since_turn >= interval) begin
                            seq_turner       = !seq_turner;
                            seq_last_turn_ms = now_ms;
                            s.turn_event     = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        if (s.setpoint_valid) begin
            cur        = program_phase(seq_prog, seq_phase[0]);
            s.temp     = cur.temp;
            s.humidity = cur.hum;
        end
        s.mode            = seq_mode;
        s.phase           = seq_phase;
        s.days            = seq_days;
        s.hours           = seq_hours;
        s.turner_position = seq_turner;
        return s;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int unsigned got, input int unsigned want);
        if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic send_request(input logic [2:0] op, input logic [2:0] sel,
                                input logic [31:0] now_ms);
        int unsigned gap;
        if ($urandom_range(0, 40) == 0) send_quiet = !send_quiet;
        gap = send_quiet ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, now_ms, sel};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        pending_status.push_back(sequencer_next_status(op, sel, now_ms));
        requests_sent++;
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_status.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed_cases();
        send_request(CMD_TICK, 3'd0, 32'd0);
        send_request(CMD_PAUSE, 3'd0, 32'd1);
        send_request(CMD_RESUME, 3'd0, 32'd2);
        send_request(CMD_STOP, 3'd0, 32'd3);
        send_request(CMD_START, 3'd5, 32'd4);
        send_request(CMD_START, 3'd6, 32'd5);
        send_request(CMD_START, 3'd7, 32'd6);
        // The program starts just below the wrap of the millisecond counter.
        send_request(CMD_START, 3'd0, WRAP_START);
        send_request(CMD_TICK, 3'd7, WRAP_START + 4 * MS_HOUR - 1);
        send_request(CMD_TICK, 3'd0, WRAP_START + 4 * MS_HOUR);
        send_request(CMD_PAUSE, 3'd0, WRAP_START + 5 * MS_HOUR);
        send_request(CMD_PAUSE, 3'd0, WRAP_START + 6 * MS_HOUR);
        send_request(CMD_TICK, 3'd0, WRAP_START + 9 * MS_HOUR);
        send_request(CMD_RESUME, 3'd0, WRAP_START + 10 * MS_HOUR);
        send_request(CMD_RESUME, 3'd0, WRAP_START + 11 * MS_HOUR);
        send_request(CMD_TICK, 3'd0, WRAP_START + 18 * MS_DAY);
        send_request(CMD_TICK, 3'd0, WRAP_START + 21 * MS_DAY - 1);
        send_request(CMD_TICK, 3'd0, WRAP_START + 21 * MS_DAY);
        send_request(CMD_TICK, 3'd0, WRAP_START + 22 * MS_DAY);
        send_request(CMD_RESUME, 3'd0, WRAP_START + 22 * MS_DAY);
        send_request(3'd5, 3'd1, 32'hFFFF_FFFF);
        send_request(3'd6, 3'd2, 32'h5555_5555);
        send_request(3'd7, 3'd4, 32'hAAAA_AAAA);
        send_request(CMD_START, 3'd4, 32'hFFFF_FFFF);
        send_request(CMD_TICK, 3'd0, 32'd0);
        // A tick just before the program start looks like the longest elapsed time.
        send_request(CMD_TICK, 3'd0, 32'hFFFF_FFFE);
        send_request(CMD_STOP, 3'd3, 32'd0);
    endtask

    task automatic test_program_runs(input int unsigned count);
        int unsigned stop_at;
        int unsigned steps;
        int unsigned pick;
        int unsigned extra;
        logic [31:0] now_ms;
        phase_t      cur;
        stop_at = requests_sent + count;
        while (requests_sent < stop_at) begin
            now_ms = $urandom();
            if ($urandom_range(0, 9) == 0)
                send_request(CMD_START, 3'($urandom_range(5, 7)), now_ms);
            else
                send_request(CMD_START, 3'($urandom_range(0, 4)), now_ms);
            steps = 0;
            while (seq_mode != MODE_DONE && seq_mode != MODE_IDLE && steps < 300) begin
                pick = $urandom_range(0, 99);
                cur  = program_phase(seq_prog, seq_phase[0]);
                if (pick < 45)
                    now_ms = now_ms + $urandom_range(0, 5 * MS_HOUR);
                else if (pick < 70)
                    now_ms = now_ms + $urandom_range(0, 2 * MS_DAY);
                else if (pick < 78)
                    now_ms = phase_start_ms() + cur.days * MS_DAY
                             + $urandom_range(0, 2 * MS_HOUR) - MS_HOUR;
                else if (pick < 88)
                    now_ms = seq_last_turn_ms + 4 * MS_HOUR + $urandom_range(0, 2000) - 1000;
                if (pick < 88) begin
                    send_request(CMD_TICK, 3'($urandom_range(0, 7)), now_ms);
                end else if (pick < 94) begin
                    send_request(CMD_PAUSE, 3'($urandom_range(0, 7)), now_ms);
                    extra = $urandom_range(0, 3);
                    repeat (extra) begin
                        now_ms = now_ms + $urandom_range(0, 8 * MS_HOUR);
                        send_request(CMD_TICK, 3'd0, now_ms);
                    end
                    send_request(CMD_RESUME, 3'($urandom_range(0, 7)), now_ms);
                end else if (pick < 99) begin
                    send_request(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), now_ms);
                end else begin
                    send_request(CMD_STOP, 3'($urandom_range(0, 7)), now_ms);
                end
                steps++;
            end
            extra = $urandom_range(0, 2);
            repeat (extra) send_request(3'($urandom_range(0, 4)), 3'd0, now_ms + MS_DAY);
            if ($urandom_range(0, 3) == 0) wait_for_results();
        end
    endtask

    task automatic test_random_commands(input int unsigned count);
        repeat (count) send_request(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), $urandom());
    endtask

    initial begin
        int unsigned gap;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if ($urandom_range(0, 40) == 0) accept_quiet = !accept_quiet;
            gap = accept_quiet ? 0 : $urandom_range(0, 18);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_status.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                want_status = pending_status.pop_front();
                got_status  = status_t'(m_tdata[34:0]);
                check_field("accepted", got_status.accepted, want_status.accepted);
                check_field("run_state", got_status.mode, want_status.mode);
                check_field("phase_index", got_status.phase, want_status.phase);
                check_field("elapsed_days", got_status.days, want_status.days);
                check_field("elapsed_hours", got_status.hours, want_status.hours);
                check_field("setpoint_valid", got_status.setpoint_valid,
                            want_status.setpoint_valid);
                check_field("temp_setpoint", got_status.temp, want_status.temp);
                check_field("humidity_setpoint", got_status.humidity, want_status.humidity);
                check_field("turn_event", got_status.turn_event, want_status.turn_event);
                check_field("turner_position", got_status.turner_position,
                            want_status.turner_position);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        seq_mode         = MODE_IDLE;
        seq_prog         = '0;
        seq_phase        = '0;
        seq_start_ms     = '0;
        seq_last_turn_ms = '0;
        seq_turner       = 1'b0;
        seq_days         = '0;
        seq_hours        = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_program_runs(900);
        test_random_commands(300);
        test_program_runs(500);
        wait_for_results();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/tpps_pkg.sv
rtl/timed_phase_program_sequencer_top.sv
tb/tb_timed_phase_program_sequencer_top.sv
